### rtl/core/lkvc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU key/value cache package
// Shared request and result types, chain commands and register constants.
// ----------------------------------------------------------------------------
package lkvc_pkg;

  // Field widths of the request and result transactions.
  localparam int unsigned KEY_W   = 32;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned CAP_W   = 5;

  // Request kinds.
  localparam logic REQ_GET = 1'b0;
  localparam logic REQ_SET = 1'b1;

  // Register map: register index and reset value.
  localparam logic       REG_CAPACITY = 1'b0;
  localparam logic [4:0] CAP_RESET    = 5'd16;

  // Request transaction.
  typedef struct packed {
    logic               req_type;
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;
  } req_t;

  // Result transaction.
  typedef struct packed {
    logic               hit;
    logic [VALUE_W-1:0] read_value;
    logic               evicted;
    logic [KEY_W-1:0]   evicted_key;
  } rsp_t;

  // Command broadcast to every cell of the chain.
  typedef enum logic [1:0] {
    OP_NONE    = 2'd0,  // hold
    OP_PROMOTE = 2'd1,  // move the hit entry to the most recent end
    OP_SHIFT   = 2'd2,  // drop the least recent entry, insert at the top
    OP_APPEND  = 2'd3   // insert just above the top entry
  } op_t;

  // Per-cell control bundle.
  typedef struct packed {
    op_t  op;
    logic at_or_above;  // this cell lies at or above the hit entry
    logic nbr_valid;    // the next (more recent) cell holds an entry
    logic prv_valid;    // the previous (less recent) cell holds an entry
    logic cmp_en;       // capture the compare result this cycle
  } cell_ctl_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE   = 2'b01,
    ST_UPDATE = 2'b10
  } state_t;

endpackage

### rtl/core/lru_key_value_cache_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU key/value cache unit
// Fully associative get/set store kept as a chain of cells in recency order.
// ----------------------------------------------------------------------------
// For each request, in the cycle it is accepted every cell compares the key
// with its own and registers the result; in the update state that follows,
// the sequencer decodes hit, eviction or insertion and the cells shift toward
// the least recent end in one step while the result transaction is written to
// the output register. A new request is accepted in the cycle after that.
// While the output register still holds an untaken result, the update waits
// for it to free. Cell 0 holds the least recent entry; valid bits live in
// flip-flops, so no clearing pass follows reset.
// Capacity (register 0, addresses 0 to 3) acts as 1 when written 0 and as
// ENTRIES when written above it; a read returns the value as written.
// ----------------------------------------------------------------------------
module lru_key_value_cache_unit #(
  parameter int unsigned ENTRIES    = 16,
  parameter int unsigned KEY_BITS   = 32,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  // Request channel
  input  logic             in_valid,
  output logic             in_ready,
  input  lkvc_pkg::req_t   in_req,
  // Result channel
  output logic             out_valid,
  input  logic             out_ready,
  output lkvc_pkg::rsp_t   out_rsp,
  // Configuration port
  input  logic             cfg_psel,
  input  logic             cfg_penable,
  input  logic             cfg_pwrite,
  input  logic [2:0]       cfg_paddr,
  input  logic [31:0]      cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  import lkvc_pkg::*;

  localparam int unsigned CW = $clog2(ENTRIES + 1);
  localparam int unsigned EW = (CW > CAP_W) ? CW : CAP_W;
  localparam int unsigned NL = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  // Sequencer and request registers.
  state_t                state_r;
  state_t                state_nxt;
  logic                  req_type_r;
  logic [KEY_BITS-1:0]   req_key_r;
  logic [VALUE_BITS-1:0] req_value_r;
  logic [CW-1:0]         count_r;
  logic [CW-1:0]         count_nxt;
  logic [CAP_W-1:0]      capacity_r;
  logic                  out_valid_r;
  rsp_t                  out_rsp_r;

  // Chain signals.
  cell_ctl_t             ctl       [ENTRIES];
  logic [ENTRIES-1:0]    cell_valid;
  logic [ENTRIES-1:0]    cell_match;
  logic [KEY_BITS-1:0]   cell_key  [ENTRIES];
  logic [VALUE_BITS-1:0] cell_value[ENTRIES];
  logic [ENTRIES-1:0]    pre       [NL+1];

  logic                  accept;
  logic                  commit;
  logic                  hit;
  logic                  evict;
  op_t                   op;
  logic [KEY_BITS-1:0]   in_key;
  logic [KEY_BITS+31:0]  in_key_x;
  logic [VALUE_BITS+31:0] in_value_x;
  logic [VALUE_BITS-1:0] hit_value;
  logic [VALUE_BITS-1:0] ld_value;
  logic [VALUE_BITS+31:0] hit_value_x;
  logic [KEY_BITS+31:0]  ev_key_x;
  logic [EW-1:0]         cap_x;
  logic [EW-1:0]         cnt_x;
  logic [EW-1:0]         lim_x;
  logic                  cfg_write;

  // Handshakes.
  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == ST_IDLE);
  assign commit   = (state_r == ST_UPDATE) && (!out_valid_r || out_ready);

  // Request fields at the stored widths.
  assign in_key_x   = {{KEY_BITS{1'b0}}, in_req.key};
  assign in_key     = in_key_x[KEY_BITS-1:0];
  assign in_value_x = {{VALUE_BITS{1'b0}}, in_req.value};

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (commit) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Configuration register write and read.
  assign cfg_write  = cfg_psel && cfg_penable && cfg_pwrite && (cfg_paddr[2] == REG_CAPACITY);
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_CAPACITY) ? {{(32 - CAP_W){1'b0}}, capacity_r}
                                                     : 32'd0;

  // Eviction happens when the occupied count has reached the effective capacity.
  always_comb begin
    cap_x = EW'(capacity_r);
    cnt_x = EW'(count_r);
    if (capacity_r == '0) begin
      lim_x = EW'(1);
    end else if (cap_x > EW'(ENTRIES)) begin
      lim_x = EW'(ENTRIES);
    end else begin
      lim_x = cap_x;
    end
  end

  assign hit   = |cell_match;
  assign evict = (cnt_x >= lim_x);

  // Value of the hit entry: at most one cell matches.
  always_comb begin
    hit_value = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      hit_value = hit_value | (cell_match[i] ? cell_value[i] : '0);
    end
  end

  // Command for the chain in the update cycle.
  always_comb begin
    op = OP_NONE;
    if (commit) begin
      if (hit) begin
        op = OP_PROMOTE;
      end else if (req_type_r == REQ_SET) begin
        op = evict ? OP_SHIFT : OP_APPEND;
      end
    end
  end

  assign ld_value  = (hit && (req_type_r == REQ_GET)) ? hit_value : req_value_r;
  assign count_nxt = (op == OP_APPEND) ? (count_r + CW'(1)) : count_r;

  // Cells at or above the hit entry: log-depth prefix OR over the match vector.
  assign pre[0] = cell_match;
  for (genvar lv = 0; lv < NL; lv++) begin : g_pre
    for (genvar i = 0; i < ENTRIES; i++) begin : g_bit
      if (i >= (1 << lv)) begin : g_or
        assign pre[lv+1][i] = pre[lv][i] | pre[lv][i - (1 << lv)];
      end else begin : g_pass
        assign pre[lv+1][i] = pre[lv][i];
      end
    end
  end

  // The chain of cells.
  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    logic [KEY_BITS-1:0]   nbr_key;
    logic [VALUE_BITS-1:0] nbr_value;

    if (i < ENTRIES - 1) begin : g_nbr
      assign nbr_key            = cell_key[i+1];
      assign nbr_value          = cell_value[i+1];
      assign ctl[i].nbr_valid   = cell_valid[i+1];
    end else begin : g_end
      assign nbr_key            = '0;
      assign nbr_value          = '0;
      assign ctl[i].nbr_valid   = 1'b0;
    end

    if (i > 0) begin : g_prv
      assign ctl[i].prv_valid = cell_valid[i-1];
    end else begin : g_first
      assign ctl[i].prv_valid = 1'b1;
    end

    assign ctl[i].op          = op;
    assign ctl[i].at_or_above = pre[NL][i];
    assign ctl[i].cmp_en      = accept;

    lkvc_cell #(
      .KEY_BITS   (KEY_BITS),
      .VALUE_BITS (VALUE_BITS)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl[i]),
      .cmp_key   (in_key),
      .ld_key    (req_key_r),
      .ld_value  (ld_value),
      .nbr_key   (nbr_key),
      .nbr_value (nbr_value),
      .valid     (cell_valid[i]),
      .match     (cell_match[i]),
      .key       (cell_key[i]),
      .value     (cell_value[i])
    );
  end

  // Result fields narrowed to the transaction widths.
  assign hit_value_x = {32'd0, hit_value};
  assign ev_key_x    = {32'd0, cell_key[0]};

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      capacity_r  <= CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (cfg_write) begin
        capacity_r <= cfg_pwdata[CAP_W-1:0];
      end
      if (commit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Request and result payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      req_type_r  <= in_req.req_type;
      req_key_r   <= in_key;
      req_value_r <= in_value_x[VALUE_BITS-1:0];
    end
    if (commit) begin
      out_rsp_r.hit         <= hit;
      out_rsp_r.read_value  <= (hit && (req_type_r == REQ_GET)) ? hit_value_x[31:0] : '0;
      out_rsp_r.evicted     <= (op == OP_SHIFT);
      out_rsp_r.evicted_key <= (op == OP_SHIFT) ? ev_key_x[31:0] : '0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  // The number of valid cells always equals the occupied count.
  assert property (@(posedge clk) disable iff (!rst_n)
    $countones(cell_valid) == int'(count_r))
    else $error("valid cells disagree with the occupied count");

  // Keys in the cache are unique, so at most one cell matches.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UPDATE) |-> $onehot0(cell_match))
    else $error("more than one cell matched the request key");

  // An eviction replaces one entry and leaves the count unchanged.
  assert property (@(posedge clk) disable iff (!rst_n)
    (op == OP_SHIFT) |=> $stable(count_r))
    else $error("eviction changed the occupied count");

  // The occupied count never passes the number of cells.
  assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(ENTRIES))
    else $error("occupied count exceeds the chain length");

endmodule

### rtl/core/lkvc_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU key/value cache cell
// One slot of the recency chain: holds a key, a value and a valid bit,
// compares its key with the request and takes its neighbor's entry or the loaded one.
// ----------------------------------------------------------------------------
module lkvc_cell #(
  parameter int unsigned KEY_BITS   = 32,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  lkvc_pkg::cell_ctl_t    ctl,
  input  logic [KEY_BITS-1:0]    cmp_key,
  input  logic [KEY_BITS-1:0]    ld_key,
  input  logic [VALUE_BITS-1:0]  ld_value,
  input  logic [KEY_BITS-1:0]    nbr_key,
  input  logic [VALUE_BITS-1:0]  nbr_value,
  output logic                   valid,
  output logic                   match,
  output logic [KEY_BITS-1:0]    key,
  output logic [VALUE_BITS-1:0]  value
);
  import lkvc_pkg::*;

  logic                  valid_r;
  logic                  valid_nxt;
  logic                  match_r;
  logic                  match_nxt;
  logic [KEY_BITS-1:0]   key_r;
  logic [KEY_BITS-1:0]   key_nxt;
  logic [VALUE_BITS-1:0] value_r;
  logic [VALUE_BITS-1:0] value_nxt;
  logic                  is_top;
  logic                  is_next;
  logic                  take_nbr;
  logic                  take_ld;

  // Position of this cell relative to the occupied part of the chain.
  assign is_top  = valid_r && !ctl.nbr_valid;
  assign is_next = !valid_r && ctl.prv_valid;

  // Decode the broadcast command into this cell's move.
  always_comb begin
    take_nbr = 1'b0;
    take_ld  = 1'b0;
    case (ctl.op)
      OP_PROMOTE: begin
        take_nbr = ctl.at_or_above && ctl.nbr_valid;
        take_ld  = is_top;
      end
      OP_SHIFT: begin
        take_nbr = ctl.nbr_valid;
        take_ld  = is_top;
      end
      OP_APPEND: begin
        take_ld  = is_next;
      end
      OP_NONE: begin
        take_nbr = 1'b0;
        take_ld  = 1'b0;
      end
      default: begin
        take_nbr = 1'b0;
        take_ld  = 1'b0;
      end
    endcase
  end

  // Next state of the slot.
  always_comb begin
    valid_nxt = valid_r || ((ctl.op == OP_APPEND) && is_next);
    match_nxt = ctl.cmp_en ? (valid_r && (key_r == cmp_key)) : match_r;
    key_nxt   = key_r;
    value_nxt = value_r;
    if (take_nbr) begin
      key_nxt   = nbr_key;
      value_nxt = nbr_value;
    end else if (take_ld) begin
      key_nxt   = ld_key;
      value_nxt = ld_value;
    end
  end

  // Control bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      match_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      match_r <= match_nxt;
    end
  end

  // Slot payload.
  always_ff @(posedge clk) begin
    key_r   <= key_nxt;
    value_r <= value_nxt;
  end

  assign valid = valid_r;
  assign match = match_r;
  assign key   = key_r;
  assign value = value_r;

endmodule
